// ===== src/tsd_pkg.sv =====
package tsd_pkg;

  // Field and datapath widths
  localparam int CoordW   = 32;
  localparam int DiffW    = 33;
  localparam int ProdW    = 66;
  localparam int MinorW   = 67;
  localparam int MagW     = 66;
  localparam int HalfW    = 33;
  localparam int LoSplit  = 34;
  localparam int LoProdW  = 68;
  localparam int HiProdW  = 66;
  localparam int DetW     = 102;
  localparam int S6W      = 103;
  localparam int SqW      = 132;
  localparam int FracSh   = 16;
  localparam int RemW     = 148;
  localparam int PW       = 135;
  localparam int DeltaW   = 169;
  localparam int QW       = 32;

  localparam int NumVert  = 4;
  localparam int NumAxis  = 3;

  // Pipeline depth: three cofactor stages, two squaring stages, then the root steps
  localparam int IterN      = QW;
  localparam int FrontN     = 5;
  localparam int DegenStage = FrontN + 1;
  localparam int PipeN      = FrontN + IterN;

  localparam logic [1:0] LastVertex = 2'd3;
  localparam logic [1:0] FirstVertex = 2'd0;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t vertex0_x;
    coord_t vertex0_y;
    coord_t vertex0_z;
    coord_t vertex1_x;
    coord_t vertex1_y;
    coord_t vertex1_z;
    coord_t vertex2_x;
    coord_t vertex2_y;
    coord_t vertex2_z;
    coord_t vertex3_x;
    coord_t vertex3_y;
    coord_t vertex3_z;
  } vertices_t;

  typedef struct packed {
    logic [1:0]         vertex_index;
    logic signed [31:0] deriv_x;
    logic signed [31:0] deriv_y;
    logic signed [31:0] deriv_z;
    logic               degenerate;
    logic               last_vertex;
  } deriv_t;

  typedef logic [NumVert-1:0][NumAxis-1:0][CoordW-1:0] pos_t;

  // Per-slot control carried alongside the lanes
  typedef struct packed {
    logic       valid;
    logic [1:0] vidx;
    logic       degen;
  } slot_t;

  // Volume result handed from the determinant unit to the lanes
  typedef struct packed {
    logic [S6W-1:0] s6;
    logic           degen;
  } det_t;

  function automatic pos_t to_pos(input vertices_t v);
    pos_t p;
    p[0][0] = v.vertex0_x;
    p[0][1] = v.vertex0_y;
    p[0][2] = v.vertex0_z;
    p[1][0] = v.vertex1_x;
    p[1][1] = v.vertex1_y;
    p[1][2] = v.vertex1_z;
    p[2][0] = v.vertex2_x;
    p[2][1] = v.vertex2_y;
    p[2][2] = v.vertex2_z;
    p[3][0] = v.vertex3_x;
    p[3][1] = v.vertex3_y;
    p[3][2] = v.vertex3_z;
    return p;
  endfunction

  function automatic logic signed [DiffW-1:0] diff(input coord_t a, input coord_t b);
    return DiffW'(a) - DiffW'(b);
  endfunction

  // j-th vertex other than i, in ascending order
  function automatic logic [1:0] other_vertex(input logic [1:0] i, input logic [1:0] j);
    return (j < i) ? j : j + 2'd1;
  endfunction

  function automatic int axis_u(input int k);
    case (k)
      0:       return 1;
      1:       return 2;
      default: return 0;
    endcase
  endfunction

  function automatic int axis_v(input int k);
    case (k)
      0:       return 2;
      1:       return 0;
      default: return 1;
    endcase
  endfunction

endpackage

// ===== src/tsd_det.sv =====
module tsd_det (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              start,
  input  tsd_pkg::pos_t     pos,
  output tsd_pkg::det_t     det
);

  logic [4:1] mark;

  logic signed [tsd_pkg::DiffW-1:0]   e [3][3];
  logic signed [tsd_pkg::DiffW-1:0]   r2 [3];
  logic signed [tsd_pkg::DiffW-1:0]   r3 [3];
  logic signed [tsd_pkg::ProdW-1:0]   pa [3];
  logic signed [tsd_pkg::ProdW-1:0]   pb [3];
  logic signed [tsd_pkg::MinorW-1:0]  minor [3];
  logic signed [tsd_pkg::LoProdW-1:0] lo_prod [3];
  logic signed [tsd_pkg::HiProdW-1:0] hi_prod [3];

  logic signed [tsd_pkg::DetW-1:0] term [3];
  logic signed [tsd_pkg::DetW-1:0] det_sum;
  logic signed [tsd_pkg::S6W-1:0]  s6_sum;

  // Track where the first vertex of a request sits
  always_ff @(posedge clk) begin
    if (rst) begin
      mark <= '0;
    end else if (en) begin
      mark <= {mark[3:1], start};
    end
  end

  // Edge vectors from vertex 0
  always_ff @(posedge clk) begin
    if (en && start) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          e[i][k] <= tsd_pkg::diff(pos[i+1][k], pos[0][k]);
        end
      end
    end
  end

  // Minor products of rows two and three
  always_ff @(posedge clk) begin
    if (en && mark[1]) begin
      pa[0] <= e[1][1] * e[2][2];
      pb[0] <= e[1][2] * e[2][1];
      pa[1] <= e[1][0] * e[2][2];
      pb[1] <= e[1][2] * e[2][0];
      pa[2] <= e[1][0] * e[2][1];
      pb[2] <= e[1][1] * e[2][0];
      for (int k = 0; k < 3; k++) r2[k] <= e[0][k];
    end
  end

  always_ff @(posedge clk) begin
    if (en && mark[2]) begin
      for (int k = 0; k < 3; k++) begin
        minor[k] <= tsd_pkg::MinorW'(pa[k]) - tsd_pkg::MinorW'(pb[k]);
        r3[k]    <= r2[k];
      end
    end
  end

  // Split each minor into two partial products
  always_ff @(posedge clk) begin
    if (en && mark[3]) begin
      for (int k = 0; k < 3; k++) begin
        lo_prod[k] <= r3[k] * $signed({1'b0, minor[k][tsd_pkg::LoSplit-1:0]});
        hi_prod[k] <= r3[k] * $signed(minor[k][tsd_pkg::MinorW-1:tsd_pkg::LoSplit]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      term[k] = (tsd_pkg::DetW'(hi_prod[k]) <<< tsd_pkg::LoSplit)
              + tsd_pkg::DetW'(lo_prod[k]);
    end
    det_sum = term[0] - term[1] + term[2];
    s6_sum  = (tsd_pkg::S6W'(det_sum) <<< 2) + (tsd_pkg::S6W'(det_sum) <<< 1);
  end

  // Hold volume until the next request's first vertex arrives
  always_ff @(posedge clk) begin
    if (en && mark[4]) begin
      det.s6    <= s6_sum;
      det.degen <= det_sum[tsd_pkg::DetW-1] || (det_sum == '0);
    end
  end

endmodule

// ===== src/tsd_cofactor.sv =====
module tsd_cofactor (
  input  logic                                         clk,
  input  logic                                         en,
  input  logic [1:0]                                   vidx,
  input  tsd_pkg::pos_t                                pos,
  output logic [tsd_pkg::NumAxis-1:0][tsd_pkg::MagW-1:0] mag,
  output logic [tsd_pkg::NumAxis-1:0]                  neg
);

  logic [1:0] vp, vq, vr;

  logic signed [tsd_pkg::DiffW-1:0] ur [tsd_pkg::NumAxis];
  logic signed [tsd_pkg::DiffW-1:0] uq [tsd_pkg::NumAxis];
  logic signed [tsd_pkg::DiffW-1:0] vrd [tsd_pkg::NumAxis];
  logic signed [tsd_pkg::DiffW-1:0] vqd [tsd_pkg::NumAxis];
  logic signed [tsd_pkg::ProdW-1:0] p1 [tsd_pkg::NumAxis];
  logic signed [tsd_pkg::ProdW-1:0] p2 [tsd_pkg::NumAxis];
  logic                             c1_odd, c2_odd;

  logic signed [tsd_pkg::MinorW-1:0] dd [tsd_pkg::NumAxis];
  logic [tsd_pkg::MinorW-1:0]        ad [tsd_pkg::NumAxis];

  assign vp = tsd_pkg::other_vertex(vidx, 2'd0);
  assign vq = tsd_pkg::other_vertex(vidx, 2'd1);
  assign vr = tsd_pkg::other_vertex(vidx, 2'd2);

  // Edge differences for the three remaining vertices
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < tsd_pkg::NumAxis; k++) begin
        ur[k]  <= tsd_pkg::diff(pos[vr][tsd_pkg::axis_u(k)], pos[vp][tsd_pkg::axis_u(k)]);
        uq[k]  <= tsd_pkg::diff(pos[vq][tsd_pkg::axis_u(k)], pos[vp][tsd_pkg::axis_u(k)]);
        vrd[k] <= tsd_pkg::diff(pos[vr][tsd_pkg::axis_v(k)], pos[vp][tsd_pkg::axis_v(k)]);
        vqd[k] <= tsd_pkg::diff(pos[vq][tsd_pkg::axis_v(k)], pos[vp][tsd_pkg::axis_v(k)]);
      end
      c1_odd <= vidx[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < tsd_pkg::NumAxis; k++) begin
        p1[k] <= ur[k] * vqd[k];
        p2[k] <= uq[k] * vrd[k];
      end
      c2_odd <= c1_odd;
    end
  end

  // Cofactor as sign and magnitude; odd vertices flip the sign
  always_comb begin
    for (int k = 0; k < tsd_pkg::NumAxis; k++) begin
      dd[k] = tsd_pkg::MinorW'(p1[k]) - tsd_pkg::MinorW'(p2[k]);
      ad[k] = dd[k][tsd_pkg::MinorW-1] ? -dd[k] : dd[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < tsd_pkg::NumAxis; k++) begin
        mag[k] <= ad[k][tsd_pkg::MagW-1:0];
        neg[k] <= dd[k][tsd_pkg::MinorW-1] ^ c2_odd;
      end
    end
  end

endmodule

// ===== src/tsd_root_lane.sv =====
module tsd_root_lane (
  input  logic                     clk,
  input  logic                     en,
  input  logic [tsd_pkg::MagW-1:0] mag,
  input  logic                     neg,
  input  logic [tsd_pkg::S6W-1:0]  s6,
  output logic [tsd_pkg::QW-1:0]   q,
  output logic                     neg_out
);

  logic [tsd_pkg::ProdW-1:0] a_ll, a_hl, a_hh;
  logic                      a_neg;
  logic [tsd_pkg::SqW-1:0]   sq;
  logic [tsd_pkg::RemW-1:0]  b_r;
  logic                      b_neg;

  logic [tsd_pkg::RemW-1:0] it_r   [tsd_pkg::IterN];
  logic [tsd_pkg::PW-1:0]   it_p   [tsd_pkg::IterN];
  logic [tsd_pkg::QW-1:0]   it_q   [tsd_pkg::IterN];
  logic [tsd_pkg::S6W-1:0]  it_s6  [tsd_pkg::IterN];
  logic                     it_neg [tsd_pkg::IterN];

  logic [tsd_pkg::RemW-1:0] src_r   [tsd_pkg::IterN];
  logic [tsd_pkg::PW-1:0]   src_p   [tsd_pkg::IterN];
  logic [tsd_pkg::QW-1:0]   src_q   [tsd_pkg::IterN];
  logic [tsd_pkg::S6W-1:0]  src_s6  [tsd_pkg::IterN];
  logic                     src_neg [tsd_pkg::IterN];

  // Square the magnitude in three partial products
  always_ff @(posedge clk) begin
    if (en) begin
      a_ll  <= mag[tsd_pkg::HalfW-1:0] * mag[tsd_pkg::HalfW-1:0];
      a_hl  <= mag[tsd_pkg::MagW-1:tsd_pkg::HalfW] * mag[tsd_pkg::HalfW-1:0];
      a_hh  <= mag[tsd_pkg::MagW-1:tsd_pkg::HalfW] * mag[tsd_pkg::MagW-1:tsd_pkg::HalfW];
      a_neg <= neg;
    end
  end

  assign sq = tsd_pkg::SqW'(a_ll)
            + (tsd_pkg::SqW'(a_hl) << (tsd_pkg::HalfW + 1))
            + (tsd_pkg::SqW'(a_hh) << (2 * tsd_pkg::HalfW));

  always_ff @(posedge clk) begin
    if (en) begin
      b_r   <= tsd_pkg::RemW'(sq) << tsd_pkg::FracSh;
      b_neg <= a_neg;
    end
  end

  // Feed each root step from the one before
  always_comb begin
    src_r[0]   = b_r;
    src_p[0]   = '0;
    src_q[0]   = '0;
    src_s6[0]  = s6;
    src_neg[0] = b_neg;
    for (int j = 1; j < tsd_pkg::IterN; j++) begin
      src_r[j]   = it_r[j-1];
      src_p[j]   = it_p[j-1];
      src_q[j]   = it_q[j-1];
      src_s6[j]  = it_s6[j-1];
      src_neg[j] = it_neg[j-1];
    end
  end

  // One quotient bit per stage: add 2^k to q when (q + 2^k)^2 * s6 still fits
  for (genvar j = 0; j < tsd_pkg::IterN; j++) begin : g_step
    localparam int K = tsd_pkg::IterN - 1 - j;
    logic [tsd_pkg::DeltaW-1:0] delta;
    logic [tsd_pkg::DeltaW-1:0] rem_ext;
    logic                       take;

    assign delta   = (tsd_pkg::DeltaW'(src_p[j]) << (K + 1))
                   + (tsd_pkg::DeltaW'(src_s6[j]) << (2 * K));
    assign rem_ext = tsd_pkg::DeltaW'(src_r[j]);
    assign take    = (delta <= rem_ext);

    always_ff @(posedge clk) begin
      if (en) begin
        it_r[j]   <= take ? tsd_pkg::RemW'(rem_ext - delta) : src_r[j];
        it_p[j]   <= take ? src_p[j] + (tsd_pkg::PW'(src_s6[j]) << K) : src_p[j];
        it_q[j]   <= take ? src_q[j] | (tsd_pkg::QW'(1) << K) : src_q[j];
        it_s6[j]  <= src_s6[j];
        it_neg[j] <= src_neg[j];
      end
    end
  end

  assign q       = it_q[tsd_pkg::IterN-1];
  assign neg_out = it_neg[tsd_pkg::IterN-1];

endmodule

// ===== src/tetra_shape_derivatives.sv =====
// Shape-function gradients of a linear tetrahedron.
// Request channel (vertex_valid / vertex_ready / vertices): the four vertex
// positions in signed Q16.16. Result channel (deriv_valid / deriv_ready /
// deriv): four results per request, vertex 0 to 3 in order, last_vertex set
// on the fourth, each carrying the three saturated Q16.16 derivatives.
// A request is held in one register and fed into the datapath one vertex per
// cycle unless the receiver stalls; three root lanes (one per axis) work on
// that vertex while the volume unit runs beside them. A new request is taken
// as the last vertex of the previous one issues. The first result passes the
// cofactor, squaring and root stages and the output register; the other three
// follow one per cycle unless the receiver stalls. The lanes are 32-step
// bit-serial root/divide pipelines, one quotient bit per stage.
// A non-positive volume sets degenerate and forces the derivatives to zero.
// Reset (rst, synchronous) empties the request register and all pipeline
// slots. When the receiver stalls, the whole pipeline holds in place and the
// request register accepts a new request only once its previous one is
// fully issued.
module tetra_shape_derivatives (
  input  logic               clk,
  input  logic               rst,
  input  logic               vertex_valid,
  output logic               vertex_ready,
  input  tsd_pkg::vertices_t vertices,
  output logic               deriv_valid,
  input  logic               deriv_ready,
  output tsd_pkg::deriv_t    deriv
);

  tsd_pkg::vertices_t item;
  logic               item_valid;
  logic [1:0]         vcnt;
  logic               en;
  logic               issue;
  logic               accept;
  tsd_pkg::pos_t      pos;
  tsd_pkg::det_t      det;
  tsd_pkg::slot_t     slot [1:tsd_pkg::PipeN];

  logic [tsd_pkg::NumAxis-1:0][tsd_pkg::MagW-1:0] cof_mag;
  logic [tsd_pkg::NumAxis-1:0]                    cof_neg;
  logic [tsd_pkg::QW-1:0]                         lane_q [tsd_pkg::NumAxis];
  logic [tsd_pkg::NumAxis-1:0]                    lane_neg;

  function automatic logic signed [31:0] saturate(input logic [31:0] qv, input logic ng,
                                                  input logic dg);
    logic [31:0] m;
    if (dg) begin
      return '0;
    end
    if (ng) begin
      m = (qv > 32'h8000_0000) ? 32'h8000_0000 : qv;
      return -m;
    end
    return (qv > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : qv;
  endfunction

  // Advance everything unless a result waits
  assign en           = !deriv_valid || deriv_ready;
  assign issue        = en && item_valid;
  assign vertex_ready = !item_valid || (issue && vcnt == tsd_pkg::LastVertex);
  assign accept       = vertex_valid && vertex_ready;
  assign pos          = tsd_pkg::to_pos(item);

  // Hold the request and step through its vertices
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      vcnt       <= '0;
    end else begin
      if (issue) begin
        vcnt <= vcnt + 2'd1;
        if (vcnt == tsd_pkg::LastVertex) item_valid <= 1'b0;
      end
      if (accept) item_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item <= vertices;
  end

  tsd_det u_det (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .start (issue && vcnt == tsd_pkg::FirstVertex),
    .pos   (pos),
    .det   (det)
  );

  tsd_cofactor u_cofactor (
    .clk  (clk),
    .en   (en),
    .vidx (vcnt),
    .pos  (pos),
    .mag  (cof_mag),
    .neg  (cof_neg)
  );

  for (genvar k = 0; k < tsd_pkg::NumAxis; k++) begin : g_lane
    tsd_root_lane u_lane (
      .clk     (clk),
      .en      (en),
      .mag     (cof_mag[k]),
      .neg     (cof_neg[k]),
      .s6      (det.s6),
      .q       (lane_q[k]),
      .neg_out (lane_neg[k])
    );
  end

  // Slot control beside the lanes; pick up the volume flag as slots enter the root steps
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= tsd_pkg::PipeN; s++) slot[s] <= '0;
    end else if (en) begin
      slot[1] <= '{valid: issue, vidx: vcnt, degen: 1'b0};
      for (int s = 2; s <= tsd_pkg::PipeN; s++) begin
        if (s == tsd_pkg::DegenStage) begin
          slot[s] <= '{valid: slot[s-1].valid, vidx: slot[s-1].vidx, degen: det.degen};
        end else begin
          slot[s] <= slot[s-1];
        end
      end
    end
  end

  // Merge the three lanes into one result
  always_ff @(posedge clk) begin
    if (rst) begin
      deriv_valid <= 1'b0;
    end else if (en) begin
      deriv_valid <= slot[tsd_pkg::PipeN].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deriv.vertex_index <= slot[tsd_pkg::PipeN].vidx;
      deriv.deriv_x      <= saturate(lane_q[0], lane_neg[0], slot[tsd_pkg::PipeN].degen);
      deriv.deriv_y      <= saturate(lane_q[1], lane_neg[1], slot[tsd_pkg::PipeN].degen);
      deriv.deriv_z      <= saturate(lane_q[2], lane_neg[2], slot[tsd_pkg::PipeN].degen);
      deriv.degenerate   <= slot[tsd_pkg::PipeN].degen;
      deriv.last_vertex  <= (slot[tsd_pkg::PipeN].vidx == tsd_pkg::LastVertex);
    end
  end

endmodule

// ===== src/tsd_checker.sv =====
module tsd_checker (
  input logic            clk,
  input logic            rst,
  input logic            vertex_valid,
  input logic            vertex_ready,
  input logic            deriv_valid,
  input logic            deriv_ready,
  input tsd_pkg::deriv_t deriv
);

  logic [7:0] pending;
  logic [1:0] delivered;

  // Count results owed and results taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      delivered <= '0;
    end else begin
      pending <= pending + ((vertex_valid && vertex_ready) ? 8'd4 : 8'd0)
                         - ((deriv_valid && deriv_ready) ? 8'd1 : 8'd0);
      if (deriv_valid && deriv_ready) delivered <= delivered + 2'd1;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !deriv_valid)
    else $error("result valid right after reset");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    deriv_valid |-> pending != 8'd0)
    else $error("result shown with no request outstanding");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    deriv_valid && !deriv_ready |=> deriv_valid && $stable(deriv))
    else $error("stalled result changed");

  a_vertex_order: assert property (@(posedge clk) disable iff (rst)
    deriv_valid |-> deriv.vertex_index == delivered
                 && deriv.last_vertex == (delivered == 2'd3))
    else $error("result out of vertex order");

endmodule

bind tetra_shape_derivatives tsd_checker u_tsd_checker (.*);

// ===== sim/tetra_shape_derivatives_checker.sv =====
`timescale 1ns / 100ps

module tetra_shape_derivatives_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               vertex_valid,
  input  logic               vertex_ready,
  input  tsd_pkg::vertices_t vertices,
  input  logic               deriv_valid,
  input  logic               deriv_ready,
  input  tsd_pkg::deriv_t    deriv,
  output int                 fails,
  output int                 pending
);

  typedef logic signed [191:0] wide_t;
  typedef logic [191:0]        uwide_t;

  wide_t            corner [4][3];
  tsd_pkg::deriv_t  expected_derivs[$];

  // Cofactor (u_r - u_p)(v_q - v_p) - (u_q - u_p)(v_r - v_p)
  function automatic wide_t cofactor(int ua, int va, int p, int q, int r);
    return (corner[r][ua] - corner[p][ua]) * (corner[q][va] - corner[p][va])
         - (corner[q][ua] - corner[p][ua]) * (corner[r][va] - corner[p][va]);
  endfunction

  // Truncated b * 2^8 / sqrt(s6) with saturation to 32 bits
  function automatic logic [31:0] root_quotient(wide_t b, wide_t s6);
    logic    neg;
    uwide_t  mag;
    uwide_t  mag_sq;
    uwide_t  trial;
    logic [63:0] q;
    logic [63:0] t;
    neg = b < 0;
    mag = neg ? uwide_t'(-b) : uwide_t'(b);
    mag = mag << 8;
    mag_sq = mag * mag;
    q = '0;
    for (int bit_i = 31; bit_i >= 0; bit_i--) begin
      t = q | (64'd1 << bit_i);
      trial = uwide_t'(t * t) * uwide_t'(s6);
      if (trial <= mag_sq) q = t;
    end
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return 32'(64'd0 - q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q[31:0];
  endfunction

  // Queue the four gradients of one tetrahedron
  task automatic predict_gradients(tsd_pkg::vertices_t v);
    wide_t  e [3][3];
    wide_t  det;
    wide_t  s6;
    wide_t  c;
    logic   degen;
    int     oth [3];
    tsd_pkg::deriv_t r;
    logic [31:0] d [3];
    tsd_pkg::pos_t   p;
    p = tsd_pkg::to_pos(v);
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 3; k++)
        corner[i][k] = wide_t'($signed(p[i][k]));
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        e[i][k] = corner[i+1][k] - corner[0][k];
    det = e[0][0] * (e[1][1] * e[2][2] - e[1][2] * e[2][1])
        - e[0][1] * (e[1][0] * e[2][2] - e[1][2] * e[2][0])
        + e[0][2] * (e[1][0] * e[2][1] - e[1][1] * e[2][0]);
    degen = det <= 0;
    s6 = det * wide_t'(6);
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 3; j++) oth[j] = (j < i) ? j : j + 1;
      for (int k = 0; k < 3; k++) begin
        if (degen) begin
          d[k] = '0;
        end else begin
          c = cofactor(tsd_pkg::axis_u(k), tsd_pkg::axis_v(k), oth[0], oth[1], oth[2]);
          if (i & 1) c = -c;
          d[k] = root_quotient(c, s6);
        end
      end
      r.vertex_index = 2'(i);
      r.deriv_x = d[0];
      r.deriv_y = d[1];
      r.deriv_z = d[2];
      r.degenerate = degen;
      r.last_vertex = (2'(i) == tsd_pkg::LastVertex);
      expected_derivs = {expected_derivs, r};
    end
  endtask

  assign pending = expected_derivs.size();

  // Predict on each accepted request, compare each accepted result
  always @(posedge clk) begin
    tsd_pkg::deriv_t exp_d;
    int              errs;
    errs = 0;
    if (rst) begin
      fails <= 0;
    end else begin
      if (vertex_valid && vertex_ready) predict_gradients(vertices);
      if (deriv_valid && deriv_ready) begin
        if (expected_derivs.size() == 0) begin
          $error("unexpected result: %p", deriv);
          errs = errs + 1;
        end else begin
          exp_d = expected_derivs.pop_front();
          if (deriv.vertex_index !== exp_d.vertex_index) begin
            $error("vertex_index expected %0d actual %0d",
                   exp_d.vertex_index, deriv.vertex_index);
            errs = errs + 1;
          end
          if (deriv.deriv_x !== exp_d.deriv_x) begin
            $error("deriv_x expected %0d actual %0d", exp_d.deriv_x, deriv.deriv_x);
            errs = errs + 1;
          end
          if (deriv.deriv_y !== exp_d.deriv_y) begin
            $error("deriv_y expected %0d actual %0d", exp_d.deriv_y, deriv.deriv_y);
            errs = errs + 1;
          end
          if (deriv.deriv_z !== exp_d.deriv_z) begin
            $error("deriv_z expected %0d actual %0d", exp_d.deriv_z, deriv.deriv_z);
            errs = errs + 1;
          end
          if (deriv.degenerate !== exp_d.degenerate) begin
            $error("degenerate expected %0d actual %0d",
                   exp_d.degenerate, deriv.degenerate);
            errs = errs + 1;
          end
          if (deriv.last_vertex !== exp_d.last_vertex) begin
            $error("last_vertex expected %0d actual %0d",
                   exp_d.last_vertex, deriv.last_vertex);
            errs = errs + 1;
          end
        end
      end
      fails <= fails + errs;
    end
  end

endmodule

// ===== sim/tetra_shape_derivatives_tb.sv =====
`timescale 1ns / 100ps

module tetra_shape_derivatives_tb;

  logic               clk;
  logic               rst;
  logic               vertex_valid;
  logic               vertex_ready;
  tsd_pkg::vertices_t vertices;
  logic               deriv_valid;
  logic               deriv_ready;
  tsd_pkg::deriv_t    deriv;
  int                 fails;
  int                 pending;
  int                 burst_left;
  logic               stall_mode;

  tetra_shape_derivatives dut (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .vertex_ready (vertex_ready),
    .vertices     (vertices),
    .deriv_valid  (deriv_valid),
    .deriv_ready  (deriv_ready),
    .deriv        (deriv)
  );

  tetra_shape_derivatives_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .vertex_ready (vertex_ready),
    .vertices     (vertices),
    .deriv_valid  (deriv_valid),
    .deriv_ready  (deriv_ready),
    .deriv        (deriv),
    .fails        (fails),
    .pending      (pending)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Stall the receiver: stretches always ready, stretches of random stalls
  always @(posedge clk) begin
    if (rst) begin
      deriv_ready <= 1'b0;
      stall_mode  <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
      deriv_ready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
    end
  end

  // Drive one request and hold it until accepted, then maybe end the burst
  task automatic send_request(tsd_pkg::vertices_t v);
    vertex_valid <= 1'b1;
    vertices     <= v;
    do @(posedge clk); while (!vertex_ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      vertex_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  function automatic tsd_pkg::vertices_t build_tetra(tsd_pkg::coord_t c [12]);
    return {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9], c[10], c[11]};
  endfunction

  // Random tetrahedron: full range, clustered near a base, or small
  function automatic tsd_pkg::vertices_t random_tetra();
    tsd_pkg::coord_t c [12];
    tsd_pkg::coord_t base [3];
    int     sh;
    int     mode;
    mode = $urandom_range(0, 3);
    sh = $urandom_range(4, 30);
    for (int k = 0; k < 3; k++) base[k] = $urandom;
    for (int i = 0; i < 12; i++) begin
      case (mode)
        0:       c[i] = $urandom;
        1:       c[i] = base[i % 3] + ($signed($urandom) >>> (31 - sh));
        default: c[i] = $signed($urandom) >>> (31 - sh);
      endcase
    end
    return build_tetra(c);
  endfunction

  initial begin
    tsd_pkg::coord_t c [12];
    tsd_pkg::coord_t one;
    one = 32'sh0001_0000;
    rst          = 1'b1;
    vertex_valid = 1'b0;
    vertices     = '0;
    burst_left   = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // All vertices coincident: zero volume
    c = '{default: 32'sd0};
    send_request(build_tetra(c));
    // Unit tetrahedron, positive orientation
    c = '{0, 0, 0, one, 0, 0, 0, one, 0, 0, 0, one};
    send_request(build_tetra(c));
    // Mirrored: negative volume
    c = '{0, 0, 0, 0, one, 0, one, 0, 0, 0, 0, one};
    send_request(build_tetra(c));
    // Smallest nonzero edge: tiny volume
    c = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1};
    send_request(build_tetra(c));
    // Extreme corners, both orientations
    c = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
          32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
          32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
          32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF};
    send_request(build_tetra(c));
    c = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
          32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
          32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
          32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000};
    send_request(build_tetra(c));
    // All ones and all max
    c = '{default: 32'sh7FFF_FFFF};
    send_request(build_tetra(c));
    c = '{default: -32'sd1};
    send_request(build_tetra(c));
    // Nearly flat sliver with long edges
    c = '{0, 0, 0, 32'sh4000_0000, 0, 0, 0, 32'sh4000_0000, 0, 1, 1, 1};
    send_request(build_tetra(c));
    // Large positive tetrahedron
    c = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
          32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
          32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
          32'sh8000_0000, 32'sh8000_0000, 1};
    send_request(build_tetra(c));

    for (int n = 0; n < 450; n++) begin
      // Hold off once until the pipeline drains
      if (n == 200) begin
        vertex_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      send_request(random_tetra());
    end
    vertex_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fails == 0) begin
      $display("tetra_shape_derivatives regression: pass");
    end else begin
      $display("tetra_shape_derivatives regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tetra_shape_derivatives regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tsd_pkg.sv
src/tsd_det.sv
src/tsd_cofactor.sv
src/tsd_root_lane.sv
src/tetra_shape_derivatives.sv
src/tsd_checker.sv
sim/tetra_shape_derivatives_checker.sv
sim/tetra_shape_derivatives_tb.sv
